/* rtl/core/replica_read_selector_assert.svh */
// ============================================================================
// Assertion macros for the replica read selector
// Clocked on clk, disabled while rst_n is low, reporting through $error.
// ============================================================================
`ifndef REPLICA_READ_SELECTOR_ASSERT_SVH
`define REPLICA_READ_SELECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every rising edge outside reset.
`define RRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be true at a rising edge outside reset.
`define RRS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RRS_ASSERT(label, prop, msg)
`define RRS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* rtl/core/rrs_pkg.sv */
// ============================================================================
// Replica read selector package
// Shared widths, register indexes and controller/datapath command types.
// ============================================================================
package rrs_pkg;

    localparam int MAX_REPLICAS_DEF = 8;
    localparam int BLOCK_W          = 16;
    localparam int COUNT_W          = 4;
    localparam int MASK_W           = 8;
    localparam int SEL_W            = 3;
    localparam int ROT_W            = 32;
    localparam int BSS_W            = 33;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;

    typedef enum logic
    {
        REG_THRESHOLD = 1'b0,
        REG_ROTATE    = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic load;
        logic update;
        logic div_step;
        logic search_step;
        logic out_load;
    } rrs_cmd_t;

    typedef struct packed
    {
        logic div_last;
        logic search_done;
        logic out_free;
    } rrs_status_t;

endpackage

/* rtl/core/rrs_if.sv */
// ============================================================================
// Replica read selector channels
// Request and response channels with a valid/ready handshake.
// ============================================================================
interface rrs_req_if;
    import rrs_pkg::*;

    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] block_count;
    logic [COUNT_W-1:0] replica_count;
    logic [MASK_W-1:0]  healthy_mask;

    modport source (output valid, output block_count, output replica_count,
                    output healthy_mask, input ready);
    modport sink   (input valid, input block_count, input replica_count,
                    input healthy_mask, output ready);
endinterface

interface rrs_rsp_if;
    import rrs_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEL_W-1:0] selected_replica;
    logic             health_redirected;

    modport source (output valid, output selected_replica, output health_redirected,
                    input ready);
    modport sink   (input valid, input selected_replica, input health_redirected,
                    output ready);
endinterface

/* rtl/core/rrs_datapath.sv */
// ============================================================================
// Replica read selector datapath
// Rotation state, serial modulo unit, health search and output register.
// ============================================================================
`include "replica_read_selector_assert.svh"

module rrs_datapath #(
    parameter int MAX_REPLICAS = rrs_pkg::MAX_REPLICAS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rrs_pkg::rrs_cmd_t                cmd,
    output rrs_pkg::rrs_status_t             status,
    input  logic [rrs_pkg::ROT_W-1:0]        switch_threshold,
    input  logic                             rotate_enable,
    input  logic [rrs_pkg::BLOCK_W-1:0]      block_count,
    input  logic [rrs_pkg::COUNT_W-1:0]      replica_count,
    input  logic [rrs_pkg::MASK_W-1:0]       healthy_mask,
    output logic [rrs_pkg::SEL_W-1:0]        selected_replica,
    output logic                             health_redirected,
    output logic                             out_valid,
    input  logic                             out_ready
);
    import rrs_pkg::*;

    localparam int CNT_W   = $clog2(MAX_REPLICAS + 1);
    localparam int IDX_W   = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam int DCNT_W  = $clog2(ROT_W);

    logic [ROT_W-1:0]   rot_reg;
    logic [BSS_W-1:0]   bss_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [ROT_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [IDX_W-1:0]   cand_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   step_reg;
    logic [IDX_W-1:0]   pick_reg;
    logic               moved_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic               redir_reg;
    logic               out_valid_reg;

    logic [CNT_W-1:0]   count_clamp;
    logic [BSS_W-1:0]   bss_sum;
    logic               thr_hit;
    logic [ROT_W-1:0]   rot_upd;
    logic [BSS_W-1:0]   bss_upd;
    logic [CNT_W:0]     rem_sh;
    logic [CNT_W-1:0]   rem_new;
    logic               div_last;
    logic [IDX_W+3:0]   idx_wide;
    logic               healthy;
    logic               last_step;
    logic               search_done;
    logic [IDX_W-1:0]   pick_now;
    logic               moved_now;
    logic [CNT_W-1:0]   idx_inc;
    logic [IDX_W+2:0]   pick_wide;
    logic               out_free;

    always_comb
    begin
        if (replica_count == '0)
        begin
            count_clamp = CNT_W'(1);
        end
        else if (int'(replica_count) > MAX_REPLICAS)
        begin
            count_clamp = CNT_W'(MAX_REPLICAS);
        end
        else
        begin
            count_clamp = CNT_W'(replica_count);
        end
    end

    always_comb
    begin
        bss_sum = bss_reg + BSS_W'(blk_reg);
        thr_hit = (bss_sum >= BSS_W'(switch_threshold));
        if (thr_hit)
        begin
            rot_upd = rot_reg + ROT_W'(1);
            bss_upd = '0;
        end
        else
        begin
            rot_upd = rot_reg;
            bss_upd = bss_sum;
        end
    end

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[ROT_W-1]};
        rem_new  = (rem_sh >= (CNT_W+1)'(count_reg)) ?
                   CNT_W'(rem_sh - (CNT_W+1)'(count_reg)) : CNT_W'(rem_sh);
        div_last = (dcnt_reg == DCNT_W'(ROT_W - 1));
    end

    always_comb
    begin
        idx_wide    = (IDX_W+4)'(idx_reg);
        healthy     = (idx_wide < (IDX_W+4)'(MASK_W)) && mask_reg[idx_wide[2:0]];
        last_step   = (step_reg == count_reg - CNT_W'(1));
        search_done = healthy || last_step;
        pick_now    = healthy ? idx_reg : cand_reg;
        moved_now   = (pick_now != cand_reg);
        idx_inc     = CNT_W'(idx_reg) + CNT_W'(1);
        pick_wide   = (IDX_W+3)'(pick_reg);
        out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
            bss_reg <= '0;
        end
        else if (cmd.update && rotate_enable)
        begin
            rot_reg <= rot_upd;
            bss_reg <= bss_upd;
        end
        else if (cmd.search_step && search_done && moved_now && rotate_enable)
        begin
            rot_reg <= ROT_W'(pick_now);
            bss_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blk_reg   <= block_count;
            count_reg <= count_clamp;
            mask_reg  <= healthy_mask;
        end
        if (cmd.update)
        begin
            quo_reg  <= rotate_enable ? rot_upd : '0;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[ROT_W-2:0], 1'b0};
            rem_reg  <= rem_new;
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
            if (div_last)
            begin
                cand_reg <= IDX_W'(rem_new);
                idx_reg  <= IDX_W'(rem_new);
                step_reg <= '0;
            end
        end
        if (cmd.search_step)
        begin
            idx_reg  <= (idx_inc == count_reg) ? '0 : IDX_W'(idx_inc);
            step_reg <= step_reg + CNT_W'(1);
            if (search_done)
            begin
                pick_reg  <= pick_now;
                moved_reg <= moved_now;
            end
        end
        if (cmd.out_load)
        begin
            sel_reg   <= pick_wide[SEL_W-1:0];
            redir_reg <= moved_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.div_last    = div_last;
    assign status.search_done = search_done;
    assign status.out_free    = out_free;

    assign selected_replica  = sel_reg;
    assign health_redirected = redir_reg;
    assign out_valid         = out_valid_reg;

    `RRS_ASSERT(a_rem_in_range, cmd.div_step |=> (rem_reg < count_reg), "remainder out of range")
    `RRS_ASSERT(a_pick_in_range, (cmd.search_step && search_done) |=> (pick_reg < count_reg), "pick out of range")
    `RRS_ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_reg && !out_ready, "pending item overwritten")

endmodule

/* rtl/core/rrs_ctrl.sv */
// ============================================================================
// Replica read selector controller
// Sequences one item through update, modulo, health search and output.
// ============================================================================
`include "replica_read_selector_assert.svh"

module rrs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rrs_pkg::rrs_status_t status,
    output rrs_pkg::rrs_cmd_t    cmd
);
    import rrs_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_WRITE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    `RRS_ASSERT(a_accept_update, (in_valid && in_ready) |=> (state_reg == ST_UPDATE), "accept did not start update")
    `RRS_ASSERT(a_update_divide, (state_reg == ST_UPDATE) |=> (state_reg == ST_DIVIDE), "update not followed by divide")
    `RRS_ASSERT(a_divide_search, (state_reg == ST_DIVIDE && status.div_last) |=> (state_reg == ST_SEARCH), "divide did not end in search")

endmodule

/* rtl/core/replica_read_selector.sv */
// ============================================================================
// Replica read selector
// Weighted round-robin replica choice with a skip over unhealthy replicas.
// ============================================================================
// Each request item passes from acceptance through the update step, a
// bit-serial modulo unit that reduces the rotation index by the replica
// count, and a health search that tests one replica per cycle and stops at
// the first healthy replica or after trying every replica, before its result
// is loaded into the output register. A new item is accepted
// while a finished result still waits in the output register.
// Configuration is written over APB: switch_threshold at byte address 0,
// rotate_enable at 4.
module replica_read_selector #(
    parameter int MAX_REPLICAS = rrs_pkg::MAX_REPLICAS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rrs_req_if.sink                           req,
    rrs_rsp_if.source                         rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rrs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rrs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rrs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import rrs_pkg::*;

    logic [ROT_W-1:0] threshold_reg;
    logic             rotate_reg;
    reg_index_t       reg_sel;
    logic             wr_en;
    rrs_cmd_t         cmd;
    rrs_status_t      status;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            rotate_reg    <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_THRESHOLD: threshold_reg <= pwdata[ROT_W-1:0];
                REG_ROTATE:    rotate_reg    <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_ROTATE:    prdata = APB_DATA_W'(rotate_reg);
            default:       prdata = '0;
        endcase
    end

    rrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rrs_datapath #(
        .MAX_REPLICAS (MAX_REPLICAS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .switch_threshold  (threshold_reg),
        .rotate_enable     (rotate_reg),
        .block_count       (req.block_count),
        .replica_count     (req.replica_count),
        .healthy_mask      (req.healthy_mask),
        .selected_replica  (rsp.selected_replica),
        .health_redirected (rsp.health_redirected),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready)
    );

endmodule

/* verif/tb.sv */
// ============================================================================
// Replica read selector testbench
// Drives read requests and register writes into the selector, predicts each
// chosen replica with its own model of the rotation and the health search,
// and compares every response item in order, under random stalls on both
// channels.
// ============================================================================
module tb;
    import rrs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 60;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int LONG_HOLD    = 400;
    localparam int PRINT_CAP    = 50;

    typedef struct packed
    {
        logic [SEL_W-1:0] replica;
        logic             redirected;
    } choice_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rrs_req_if req ();
    rrs_rsp_if rsp ();

    replica_read_selector u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [ROT_W-1:0] rotation_pos;
    logic [BSS_W-1:0] blocks_accum;
    logic [31:0]      threshold_q;
    logic             rotate_q;

    choice_t     pending_choices[$];
    int          err_cnt;
    int          requests_sent;
    int          redirects_seen;
    int          reg_writes;
    int          input_stall_cycles;
    int          cycle_cnt;
    int          sink_hold_req;
    bit          src_calm;
    bit          sink_calm;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_error(input string what);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("[%0t] ERROR: %s", $time, what);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic choice_t choose_replica(input logic [BLOCK_W-1:0] blocks,
                                               input logic [COUNT_W-1:0] count_in,
                                               input logic [MASK_W-1:0]  mask);
        int unsigned n;
        int unsigned cand;
        int unsigned pick;
        int unsigned slot;
        int unsigned s;
        bit          found;
        choice_t     c;
        n = (count_in == 0) ? 1 : ((count_in > MAX_REPLICAS_DEF) ? MAX_REPLICAS_DEF : count_in);
        cand = 0;
        if (rotate_q)
        begin
            blocks_accum = blocks_accum + BSS_W'(blocks);
            if (blocks_accum >= BSS_W'(threshold_q))
            begin
                rotation_pos = rotation_pos + 1;
                blocks_accum = '0;
            end
            cand = rotation_pos % n;
        end
        pick = cand;
        found = 1'b0;
        for (s = 0; s < n && !found; s++)
        begin
            slot = (cand + s) % n;
            if (mask[slot])
            begin
                pick = slot;
                found = 1'b1;
            end
        end
        c.redirected = (pick != cand);
        if (c.redirected && rotate_q)
        begin
            rotation_pos = pick;
            blocks_accum = '0;
        end
        c.replica = pick[SEL_W-1:0];
        return c;
    endfunction

    task automatic send_request(input logic [BLOCK_W-1:0] blocks,
                                input logic [COUNT_W-1:0] count,
                                input logic [MASK_W-1:0]  mask);
        choice_t c;
        int      gap;
        req.valid         <= 1'b1;
        req.block_count   <= blocks;
        req.replica_count <= count;
        req.healthy_mask  <= mask;
        do
            @(posedge clk);
        while (!req.ready);
        c = choose_replica(blocks, count, mask);
        pending_choices.push_back(c);
        requests_sent++;
        if (c.redirected)
            redirects_seen++;
        gap = src_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending_choices.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] want;
        wait_drain();
        paddr   <= APB_ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_THRESHOLD)
            threshold_q = value;
        else
            rotate_q = value[0];
        reg_writes++;
        want = (idx == REG_THRESHOLD) ? value : {31'b0, value[0]};
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== want)
            report_error($sformatf("register %s reads back %h, wrote %h",
                                   idx.name(), prdata, want));
    endtask

    task automatic check_choice(input logic [SEL_W-1:0] replica, input logic redirected);
        choice_t c;
        if (pending_choices.size() == 0)
        begin
            report_error($sformatf("response item with nothing pending: replica %0d",
                                   replica));
            return;
        end
        c = pending_choices.pop_front();
        if (replica !== c.replica)
            report_error($sformatf("selected_replica is %0d, predicted %0d",
                                   replica, c.replica));
        if (redirected !== c.redirected)
            report_error($sformatf("health_redirected is %b, predicted %b",
                                   redirected, c.redirected));
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                check_choice(rsp.selected_replica, rsp.health_redirected);
            if (sink_hold_req > 0)
            begin
                stall_left = sink_hold_req;
                sink_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                stall_left = sink_calm ? 0 : idle_len();
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp.ready <= 1'b0;
                end
                else
                    rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        input_stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (req.valid && !req.ready)
                input_stall_cycles++;
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("replica_read_selector: mismatch");
                $finish;
            end
        end
    end

    task automatic test_special_cases();
        write_cfg(REG_THRESHOLD, 32'd0);
        write_cfg(REG_ROTATE, 32'd1);
        send_request(16'd0, 4'd1, 8'h01);
        send_request(16'd0, 4'd0, 8'h00);
        send_request(16'd5, 4'd15, 8'hFF);
        send_request(16'd7, 4'd9, 8'h00);
        send_request(16'hFFFF, 4'd8, 8'h80);
        send_request(16'd1, 4'd4, 8'hF0);
        send_request(16'd2, 4'd3, 8'h04);
        send_request(16'd3, 4'd8, 8'h55);
        send_request(16'd0, 4'd2, 8'hFE);
        send_request(16'd0, 4'd8, 8'hFF);
    endtask

    task automatic test_threshold();
        write_cfg(REG_THRESHOLD, 32'd100);
        send_request(16'd40, 4'd5, 8'hFF);
        send_request(16'd40, 4'd5, 8'hFF);
        send_request(16'd40, 4'd5, 8'hFF);
        send_request(16'd0, 4'd5, 8'hFF);
        write_cfg(REG_THRESHOLD, 32'hFFFF_FFFF);
        send_request(16'hFFFF, 4'd8, 8'hFF);
        send_request(16'hFFFF, 4'd8, 8'hFF);
        send_request(16'hFFFF, 4'd8, 8'h7F);
    endtask

    task automatic test_rotation_off();
        write_cfg(REG_THRESHOLD, 32'd0);
        write_cfg(REG_ROTATE, 32'd0);
        send_request(16'd10, 4'd8, 8'hFF);
        send_request(16'd10, 4'd8, 8'hFE);
        send_request(16'd10, 4'd8, 8'h00);
        send_request(16'd10, 4'd0, 8'hFF);
        send_request(16'd10, 4'd8, 8'hFF);
        write_cfg(REG_ROTATE, 32'd1);
    endtask

    task automatic send_random_request();
        logic [BLOCK_W-1:0] blocks;
        logic [COUNT_W-1:0] count;
        logic [MASK_W-1:0]  mask;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 10)
            blocks = '0;
        else if (r < 15)
            blocks = '1;
        else if (r < 60)
            blocks = BLOCK_W'($urandom_range(0, 200));
        else if (r < 80)
            blocks = BLOCK_W'($urandom_range(0, 5000));
        else
            blocks = BLOCK_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 85)
            count = COUNT_W'($urandom_range(1, 8));
        else if (r < 90)
            count = '0;
        else
            count = COUNT_W'($urandom_range(9, 15));
        r = $urandom_range(0, 99);
        if (r < 10)
            mask = '0;
        else if (r < 20)
            mask = '1;
        else if (r < 35)
            mask = MASK_W'(1 << $urandom_range(0, 7));
        else
            mask = MASK_W'($urandom);
        send_request(blocks, count, mask);
    endtask

    task automatic test_backpressure();
        int k;
        wait_drain();
        src_calm = 1'b1;
        sink_hold_req = LONG_HOLD;
        for (k = 0; k < 12; k++)
            send_random_request();
        wait_drain();
        src_calm = 1'b0;
    endtask

    task automatic test_random();
        int          p;
        int          k;
        logic [31:0] thr;
        for (p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 7))
                0: thr = 32'd0;
                1: thr = 32'd1;
                2: thr = $urandom_range(2, 300);
                3: thr = $urandom_range(300, 20000);
                4: thr = 32'd65535;
                5: thr = $urandom_range(65536, 300000);
                6: thr = 32'hFFFF_FFFF;
                default: thr = $urandom;
            endcase
            if (p == 0)
                thr = 32'd0;
            if (p == 1)
                thr = 32'hFFFF_FFFF;
            write_cfg(REG_THRESHOLD, thr);
            write_cfg(REG_ROTATE, (p == 2) ? 32'd0 : 32'($urandom_range(0, 4) != 0));
            src_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    wait_drain();
                send_random_request();
            end
        end
        src_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    initial
    begin
        err_cnt = 0;
        requests_sent = 0;
        redirects_seen = 0;
        reg_writes = 0;
        sink_hold_req = 0;
        src_calm = 1'b0;
        sink_calm = 1'b0;
        rotation_pos = '0;
        blocks_accum = '0;
        threshold_q = '0;
        rotate_q = 1'b1;
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.block_count   <= '0;
        req.replica_count <= '0;
        req.healthy_mask  <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_threshold();
        test_rotation_off();
        test_backpressure();
        test_random();

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        $display("Checked %0d read requests across %0d register writes.",
                 requests_sent, reg_writes);
        $display("%0d choices were moved by the health search; input held off %0d cycles.",
                 redirects_seen, input_stall_cycles);
        if (err_cnt == 0)
            $display("replica_read_selector: match");
        else
            $display("replica_read_selector: mismatch");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rrs_pkg.sv
rtl/core/rrs_if.sv
rtl/core/rrs_datapath.sv
rtl/core/rrs_ctrl.sv
rtl/core/replica_read_selector.sv
verif/tb.sv
